// File: hw/rtl/rdcw_pkg.sv
// ----------------------------------------------------------------------------
// rdcw_pkg: shared types and codes for the distinct-count window block
// Holds the fixed field widths, the datapath operation codes, the histogram
// step codes and the command and status structs between controller and
// datapath.
// ----------------------------------------------------------------------------
package rdcw_pkg;

    // Fixed widths of the request and response fields.
    localparam int IDX_W = 10;
    localparam int VAL_W = 10;
    localparam int OUT_W = 11;

    typedef logic [2:0] t_dp_op;
    typedef logic [2:0] t_step;

    // Datapath operations.
    localparam t_dp_op OP_NONE    = 3'd0;
    localparam t_dp_op OP_CLEAR   = 3'd1;
    localparam t_dp_op OP_LOAD    = 3'd2;
    localparam t_dp_op OP_RD_ELEM = 3'd3;
    localparam t_dp_op OP_RD_CNT  = 3'd4;
    localparam t_dp_op OP_UPD     = 3'd5;
    localparam t_dp_op OP_WR_ELEM = 3'd6;
    localparam t_dp_op OP_RESULT  = 3'd7;

    // Kind of histogram step under way.
    localparam t_step STEP_GROW_LO   = 3'd0;
    localparam t_step STEP_GROW_HI   = 3'd1;
    localparam t_step STEP_SHRINK_LO = 3'd2;
    localparam t_step STEP_SHRINK_HI = 3'd3;
    localparam t_step STEP_WR_OLD    = 3'd4;
    localparam t_step STEP_WR_NEW    = 3'd5;

    typedef struct packed {
        t_dp_op op;
        t_step  step;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_query;
        logic reversed;
        logic pos_ok;
        logic in_window;
        logic grow_lo;
        logic grow_hi;
        logic shrink_lo;
        logic shrink_hi;
    } t_sts;

endpackage

// File: hw/rtl/rdcw_ram.sv
// ----------------------------------------------------------------------------
// rdcw_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rdcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/rdcw_ctrl.sv
// ----------------------------------------------------------------------------
// rdcw_ctrl: sequencer for the distinct-count window block
// Runs the clearing pass, then steps each request through element reads,
// histogram read-modify-writes, element writes and the response hand-off.
// ----------------------------------------------------------------------------
module rdcw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    input  rdcw_pkg::t_sts  i_sts,
    output rdcw_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_DECIDE  = 3'd2;
    localparam logic [2:0] S_ELEM    = 3'd3;
    localparam logic [2:0] S_CNT     = 3'd4;
    localparam logic [2:0] S_UPD     = 3'd5;
    localparam logic [2:0] S_WR_ELEM = 3'd6;
    localparam logic [2:0] S_RESULT  = 3'd7;

    logic [2:0]          r_state, n_state;
    rdcw_pkg::t_step     r_step, n_step;
    logic                r_rsp_valid, n_rsp_valid;
    rdcw_pkg::t_cmd      w_cmd;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        w_cmd.op   = rdcw_pkg::OP_NONE;
        w_cmd.step = r_step;
        unique case (r_state)
            S_CLEAR: begin
                w_cmd.op = rdcw_pkg::OP_CLEAR;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    w_cmd.op = rdcw_pkg::OP_LOAD;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.is_query) begin
                    priority if (i_sts.reversed) begin
                        n_state = S_RESULT;
                    end else if (i_sts.grow_lo) begin
                        n_step  = rdcw_pkg::STEP_GROW_LO;
                        n_state = S_ELEM;
                    end else if (i_sts.grow_hi) begin
                        n_step  = rdcw_pkg::STEP_GROW_HI;
                        n_state = S_ELEM;
                    end else if (i_sts.shrink_lo) begin
                        n_step  = rdcw_pkg::STEP_SHRINK_LO;
                        n_state = S_ELEM;
                    end else if (i_sts.shrink_hi) begin
                        n_step  = rdcw_pkg::STEP_SHRINK_HI;
                        n_state = S_ELEM;
                    end else begin
                        n_state = S_RESULT;
                    end
                end else begin
                    priority if (!i_sts.pos_ok) begin
                        n_state = S_IDLE;
                    end else if (i_sts.in_window) begin
                        n_step  = rdcw_pkg::STEP_WR_OLD;
                        n_state = S_ELEM;
                    end else begin
                        n_state = S_WR_ELEM;
                    end
                end
            end
            S_ELEM: begin
                w_cmd.op = rdcw_pkg::OP_RD_ELEM;
                n_state  = S_CNT;
            end
            S_CNT: begin
                w_cmd.op = rdcw_pkg::OP_RD_CNT;
                n_state  = S_UPD;
            end
            S_UPD: begin
                w_cmd.op = rdcw_pkg::OP_UPD;
                if (r_step == rdcw_pkg::STEP_WR_OLD) begin
                    n_step  = rdcw_pkg::STEP_WR_NEW;
                    n_state = S_CNT;
                end else if (r_step == rdcw_pkg::STEP_WR_NEW) begin
                    n_state = S_WR_ELEM;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_WR_ELEM: begin
                w_cmd.op = rdcw_pkg::OP_WR_ELEM;
                n_state  = S_IDLE;
            end
            S_RESULT: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    w_cmd.op = rdcw_pkg::OP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (w_cmd.op == rdcw_pkg::OP_RESULT) begin
            n_rsp_valid = 1'b1;
        end else if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_step      <= rdcw_pkg::STEP_GROW_LO;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_cmd       = w_cmd;

`ifndef SYNTHESIS
    a_ready_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> i_sts.clr_done)
        else $error("request ready before the clearing pass finished");

    a_result_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == rdcw_pkg::OP_RESULT) |=> r_rsp_valid)
        else $error("response not presented after result load");

    a_accept_to_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state == S_DECIDE))
        else $error("accepted request not decoded");
`endif

endmodule

// File: hw/rtl/rdcw_dp.sv
// ----------------------------------------------------------------------------
// rdcw_dp: datapath for the distinct-count window block
// Holds the element and histogram memories, the window bounds, the distinct
// count, the captured request and the response register.
// ----------------------------------------------------------------------------
module rdcw_dp #(
    parameter int ARRAY_DEPTH = 1024,
    parameter int VALUE_RANGE = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rdcw_pkg::t_cmd                  i_cmd,
    output rdcw_pkg::t_sts                  o_sts,
    input  logic                            i_req_type,
    input  logic [rdcw_pkg::IDX_W-1:0]      i_position,
    input  logic [rdcw_pkg::VAL_W-1:0]      i_write_value,
    input  logic [rdcw_pkg::IDX_W-1:0]      i_range_low,
    input  logic [rdcw_pkg::IDX_W-1:0]      i_range_high,
    output logic [rdcw_pkg::OUT_W-1:0]      o_distinct_count
);

    localparam int AW   = $clog2(ARRAY_DEPTH);
    localparam int VW   = $clog2(VALUE_RANGE);
    localparam int CW   = $clog2(ARRAY_DEPTH + 1);
    localparam int MAXD = (ARRAY_DEPTH > VALUE_RANGE) ? ARRAY_DEPTH : VALUE_RANGE;
    localparam int CLRW = $clog2(MAXD + 1);

    // Control state.
    logic [CLRW-1:0] r_clr;
    logic [AW-1:0]   r_win_lo, n_win_lo;
    logic [AW-1:0]   r_win_hi, n_win_hi;
    logic [CW-1:0]   r_distinct, n_distinct;

    // Captured request and working value.
    logic                        r_is_query;
    logic                        r_reversed;
    logic                        r_pos_ok;
    logic [AW-1:0]               r_pos;
    logic [VW-1:0]               r_wval;
    logic [AW-1:0]               r_ql;
    logic [AW-1:0]               r_qr;
    logic [VW-1:0]               r_val;
    logic [rdcw_pkg::OUT_W-1:0]  r_result;

    logic            w_clr_done;
    logic [AW-1:0]   w_elem_raddr;
    logic [VW-1:0]   w_elem_rdata;
    logic            w_elem_we;
    logic [AW-1:0]   w_elem_waddr;
    logic [VW-1:0]   w_elem_wdata;
    logic [VW-1:0]   w_hval;
    logic [CW-1:0]   w_cnt;
    logic            w_cnt_we;
    logic [VW-1:0]   w_cnt_waddr;
    logic [CW-1:0]   w_cnt_wdata;
    logic            w_insert;

    assign w_clr_done = (r_clr == CLRW'(MAXD));

    // Element read address follows the step kind.
    always_comb begin
        unique case (i_cmd.step)
            rdcw_pkg::STEP_GROW_LO:   w_elem_raddr = r_win_lo - AW'(1);
            rdcw_pkg::STEP_GROW_HI:   w_elem_raddr = r_win_hi + AW'(1);
            rdcw_pkg::STEP_SHRINK_LO: w_elem_raddr = r_win_lo;
            rdcw_pkg::STEP_SHRINK_HI: w_elem_raddr = r_win_hi;
            default:                  w_elem_raddr = r_pos;
        endcase
    end

    assign w_hval   = (i_cmd.step == rdcw_pkg::STEP_WR_NEW) ? r_wval : w_elem_rdata;
    assign w_insert = (i_cmd.step == rdcw_pkg::STEP_GROW_LO) ||
                      (i_cmd.step == rdcw_pkg::STEP_GROW_HI) ||
                      (i_cmd.step == rdcw_pkg::STEP_WR_NEW);

    always_comb begin
        w_elem_we    = 1'b0;
        w_elem_waddr = r_pos;
        w_elem_wdata = r_wval;
        if (i_cmd.op == rdcw_pkg::OP_CLEAR) begin
            w_elem_we    = !w_clr_done && (32'(r_clr) < ARRAY_DEPTH);
            w_elem_waddr = r_clr[AW-1:0];
            w_elem_wdata = '0;
        end else if (i_cmd.op == rdcw_pkg::OP_WR_ELEM) begin
            w_elem_we = 1'b1;
        end
    end

    // Histogram read-modify-write and window movement.
    always_comb begin
        w_cnt_we    = 1'b0;
        w_cnt_waddr = r_val;
        w_cnt_wdata = w_cnt;
        n_distinct  = r_distinct;
        n_win_lo    = r_win_lo;
        n_win_hi    = r_win_hi;
        if (i_cmd.op == rdcw_pkg::OP_CLEAR) begin
            w_cnt_we    = !w_clr_done && (32'(r_clr) < VALUE_RANGE);
            w_cnt_waddr = r_clr[VW-1:0];
            w_cnt_wdata = '0;
        end else if (i_cmd.op == rdcw_pkg::OP_UPD) begin
            if (w_insert) begin
                w_cnt_we    = 1'b1;
                w_cnt_wdata = w_cnt + CW'(1);
                if (w_cnt == '0) begin
                    n_distinct = r_distinct + CW'(1);
                end
            end else if (w_cnt != '0) begin
                w_cnt_we    = 1'b1;
                w_cnt_wdata = w_cnt - CW'(1);
                if ((w_cnt == CW'(1)) && (r_distinct != '0)) begin
                    n_distinct = r_distinct - CW'(1);
                end
            end
            unique case (i_cmd.step)
                rdcw_pkg::STEP_GROW_LO:   n_win_lo = r_win_lo - AW'(1);
                rdcw_pkg::STEP_GROW_HI:   n_win_hi = r_win_hi + AW'(1);
                rdcw_pkg::STEP_SHRINK_LO: n_win_lo = r_win_lo + AW'(1);
                rdcw_pkg::STEP_SHRINK_HI: n_win_hi = r_win_hi - AW'(1);
                default: begin
                    n_win_lo = r_win_lo;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_win_lo   <= AW'(1);
            r_win_hi   <= '0;
            r_distinct <= '0;
        end else begin
            if ((i_cmd.op == rdcw_pkg::OP_CLEAR) && !w_clr_done) begin
                r_clr <= r_clr + CLRW'(1);
            end
            r_win_lo   <= n_win_lo;
            r_win_hi   <= n_win_hi;
            r_distinct <= n_distinct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == rdcw_pkg::OP_LOAD) begin
            r_is_query <= i_req_type;
            r_reversed <= (i_range_low > i_range_high);
            r_pos_ok   <= (32'(i_position) < ARRAY_DEPTH);
            r_pos      <= AW'(i_position);
            r_wval     <= (32'(i_write_value) >= VALUE_RANGE) ?
                          VW'(VALUE_RANGE - 1) : VW'(i_write_value);
            r_ql       <= (32'(i_range_low) >= ARRAY_DEPTH) ?
                          AW'(ARRAY_DEPTH - 1) : AW'(i_range_low);
            r_qr       <= (32'(i_range_high) >= ARRAY_DEPTH) ?
                          AW'(ARRAY_DEPTH - 1) : AW'(i_range_high);
        end
        if (i_cmd.op == rdcw_pkg::OP_RD_CNT) begin
            r_val <= w_hval;
        end
        if (i_cmd.op == rdcw_pkg::OP_RESULT) begin
            r_result <= r_reversed ? '0 : rdcw_pkg::OUT_W'(r_distinct);
        end
    end

    rdcw_ram #(
        .WIDTH (VW),
        .DEPTH (ARRAY_DEPTH)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (w_elem_we),
        .i_waddr (w_elem_waddr),
        .i_wdata (w_elem_wdata),
        .i_raddr (w_elem_raddr),
        .o_rdata (w_elem_rdata)
    );

    rdcw_ram #(
        .WIDTH (CW),
        .DEPTH (VALUE_RANGE)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_raddr (w_hval),
        .o_rdata (w_cnt)
    );

    assign o_sts.clr_done  = w_clr_done;
    assign o_sts.is_query  = r_is_query;
    assign o_sts.reversed  = r_reversed;
    assign o_sts.pos_ok    = r_pos_ok;
    assign o_sts.in_window = (r_win_lo <= r_win_hi) && (r_win_lo <= r_pos) &&
                             (r_pos <= r_win_hi);
    assign o_sts.grow_lo   = (r_win_lo > r_ql);
    assign o_sts.grow_hi   = (r_win_hi < r_qr);
    assign o_sts.shrink_lo = (r_win_lo < r_ql);
    assign o_sts.shrink_hi = (r_win_hi > r_qr);

    assign o_distinct_count = r_result;

`ifndef SYNTHESIS
    a_window_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd.op == rdcw_pkg::OP_RESULT) && !r_reversed) |->
        ((r_win_lo == r_ql) && (r_win_hi == r_qr)))
        else $error("window does not match the queried range at result time");
`endif

endmodule

// File: hw/rtl/range_distinct_count_window_top.sv
// ----------------------------------------------------------------------------
// range_distinct_count_window_top: distinct-value counter over a window
// Usage: a request on the input channel is either a write (req_type 0) that
// stores write_value at position, or a query (req_type 1) that returns the
// number of distinct values among elements range_low..range_high.
// Writes give no response; each query gives exactly one response, in order.
// A query moves the window bounds one element at a time; each element passes
// through the decide, element read, histogram read and histogram write steps.
// A write whose position lies inside the current window also steps the
// histogram, removing the old value and adding the new one.
// One request is in work at a time; the histogram memory port sets the rate.
// After reset the block clears the element and histogram memories, one
// entry a cycle, over max(ARRAY_DEPTH, VALUE_RANGE) entries with o_req_ready
// low; the window then starts empty.
// A finished response sits in an output register; a new request is taken
// while it waits. If the receiver stalls, the next query holds its result
// until the previous response has been taken.
// ----------------------------------------------------------------------------
module range_distinct_count_window_top #(
    parameter int ARRAY_DEPTH = 1024,
    parameter int VALUE_RANGE = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  logic                        i_req_type,
    input  logic [rdcw_pkg::IDX_W-1:0]  i_position,
    input  logic [rdcw_pkg::VAL_W-1:0]  i_write_value,
    input  logic [rdcw_pkg::IDX_W-1:0]  i_range_low,
    input  logic [rdcw_pkg::IDX_W-1:0]  i_range_high,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    output logic [rdcw_pkg::OUT_W-1:0]  o_distinct_count
);

    // Commands flow from the sequencer to the datapath, status flows back.
    rdcw_pkg::t_cmd w_cmd;
    rdcw_pkg::t_sts w_sts;

    rdcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // The datapath captures the request on the accept cycle, when the
    // sequencer issues its load command.
    rdcw_dp #(
        .ARRAY_DEPTH (ARRAY_DEPTH),
        .VALUE_RANGE (VALUE_RANGE)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_req_type       (i_req_type),
        .i_position       (i_position),
        .i_write_value    (i_write_value),
        .i_range_low      (i_range_low),
        .i_range_high     (i_range_high),
        .o_distinct_count (o_distinct_count)
    );

endmodule
